// ----- sv/tmms_pkg.sv -----
// ----------------------------------------------------------------------------
// tmms_pkg
// shared constants and types of the trimmed mean moisture scaler
// ----------------------------------------------------------------------------
package tmms_pkg;

  // samples per batch, legal range 3 to 64
  localparam int SAMPLE_COUNT = 16;

  localparam int SAMPLE_W     = 12;
  localparam int PCT_W        = 7;
  localparam int PERCENT_FULL = 100;
  localparam int SUM_W        = SAMPLE_W + $clog2(SAMPLE_COUNT);
  localparam int CNT_W        = $clog2(SAMPLE_COUNT);
  localparam int PROD_W       = SAMPLE_W + PCT_W;
  localparam int DIV_W        = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DVS_W        = SAMPLE_W;
  localparam int STEP_W       = $clog2(DIV_W);
  localparam int MEAN_DIVISOR = SAMPLE_COUNT - 2;
  localparam int CFG_IDX_W    = 2;

  // exact floor division of any SUM_W-bit value by MEAN_DIVISOR:
  // multiply by ceil(2^MEAN_SHIFT / MEAN_DIVISOR) and drop MEAN_SHIFT bits
  localparam int MEAN_SHIFT  = SUM_W + $clog2(MEAN_DIVISOR);
  localparam int MEAN_RECIP  = ((1 << MEAN_SHIFT) + MEAN_DIVISOR - 1) / MEAN_DIVISOR;
  localparam int MEAN_PROD_W = 2 * SUM_W + 1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRY    = 2'd0,
    REG_SOAKED = 2'd1
  } cfg_reg_e;

  // one finished batch as handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] lowest;
    logic [SAMPLE_W-1:0] highest;
  } batch_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dry;
    logic [SAMPLE_W-1:0] soaked;
  } cal_t;

endpackage

// ----- sv/tmms_front.sv -----
// ----------------------------------------------------------------------------
// tmms_front
// accumulates sum, minimum, maximum and count of each batch of samples
// ----------------------------------------------------------------------------
module tmms_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tmms_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          push_o,
  output tmms_pkg::batch_t              push_data_o,
  input  logic                          full_i
);
  import tmms_pkg::*;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SAMPLE_COUNT - 1);

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] low_q, low_d, high_q, high_d;
  logic [CNT_W-1:0]    cnt_q;
  logic                last, accept;

  assign last       = (cnt_q == LAST_IDX);
  // only the closing beat of a batch needs room in the queue
  assign in_ready_o = !(last && full_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    sum_d  = sum_q + SUM_W'(sample_i);
    low_d  = (sample_i < low_q) ? sample_i : low_q;
    high_d = (sample_i > high_q) ? sample_i : high_q;
  end

  assign push_o              = accept && last;
  assign push_data_o.sum     = sum_d;
  assign push_data_o.lowest  = low_d;
  assign push_data_o.highest = high_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      low_q  <= SAMPLE_MAX;
      high_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      if (last) begin
        sum_q  <= '0;
        low_q  <= SAMPLE_MAX;
        high_q <= '0;
        cnt_q  <= '0;
      end else begin
        sum_q  <= sum_d;
        low_q  <= low_d;
        high_q <= high_d;
        cnt_q  <= cnt_q + CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/tmms_fifo.sv -----
// ----------------------------------------------------------------------------
// tmms_fifo
// two-entry queue of finished batches between front and back
// ----------------------------------------------------------------------------
module tmms_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tmms_pkg::batch_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tmms_pkg::batch_t pop_data_o
);
  import tmms_pkg::*;

  batch_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign full_o     = (fill_q == 2'd2);
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- sv/tmms_back.sv -----
// ----------------------------------------------------------------------------
// tmms_back
// trimmed mean by reciprocal multiply, percentage scaling on a radix-2 divider
// ----------------------------------------------------------------------------
module tmms_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  tmms_pkg::batch_t           batch_i,
  output logic                       pop_o,
  input  tmms_pkg::cal_t             cal_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tmms_pkg::PCT_W-1:0]    moisture_percent_o,
  output logic [tmms_pkg::SAMPLE_W-1:0] trimmed_average_o,
  output logic                       bad_calibration_o
);
  import tmms_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_SCALE,
    ST_PCT,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic [DIV_W-1:0]    dvd_q, dvd_d;
  logic [DVS_W-1:0]    rem_q, rem_d, dvs_q;
  logic [DVS_W:0]      rem_sh;
  logic [STEP_W-1:0]   step_q;
  logic                ge;
  logic [SAMPLE_W-1:0] mean_q, clamp_lo, clamped, diff;
  logic [PROD_W-1:0]   prod;
  logic [MEAN_PROD_W-1:0] mean_prod;
  logic [PCT_W-1:0]    pct_q;
  logic                bad, bad_q;
  logic [SUM_W-1:0]    trimmed;
  logic                out_valid_q;
  logic [PCT_W-1:0]    out_pct_q;
  logic [SAMPLE_W-1:0] out_mean_q;
  logic                out_bad_q;

  // one quotient bit per cycle, msb first
  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_W-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    rem_d  = ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
    dvd_d  = {dvd_q[DIV_W-2:0], ge};
  end

  // lowest and highest are part of the sum, so no underflow
  assign trimmed = batch_i.sum - SUM_W'(batch_i.lowest) - SUM_W'(batch_i.highest);

  // registered trimmed sum times the reciprocal of the batch divisor
  assign mean_prod = MEAN_PROD_W'(dvd_q[SUM_W-1:0]) * MEAN_PROD_W'(MEAN_RECIP);

  always_comb begin
    bad      = (cal_i.soaked >= cal_i.dry);
    clamp_lo = (mean_q <= cal_i.soaked) ? cal_i.soaked : mean_q;
    clamped  = (clamp_lo >= cal_i.dry) ? cal_i.dry : clamp_lo;
    diff     = cal_i.dry - clamped;
    prod     = PROD_W'(diff) * PROD_W'(PERCENT_FULL);
  end

  assign pop_o = (state_q == ST_IDLE) && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            dvd_q   <= DIV_W'(trimmed);
            state_q <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          mean_q  <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          bad_q <= bad;
          if (bad) begin
            pct_q   <= '0;
            state_q <= ST_OUT;
          end else begin
            dvd_q   <= DIV_W'(prod);
            dvs_q   <= cal_i.dry - cal_i.soaked;
            rem_q   <= '0;
            step_q  <= STEP_W'(DIV_W - 1);
            state_q <= ST_PCT;
          end
        end
        ST_PCT: begin
          dvd_q  <= dvd_d;
          rem_q  <= rem_d;
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            pct_q   <= dvd_d[PCT_W-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_pct_q   <= pct_q;
            out_mean_q  <= mean_q;
            out_bad_q   <= bad_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign moisture_percent_o = out_pct_q;
  assign trimmed_average_o  = out_mean_q;
  assign bad_calibration_o  = out_bad_q;

  a_bad_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> out_pct_q == '0)
    else $error("bad calibration with nonzero percentage");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pct_q <= PCT_W'(PERCENT_FULL))
    else $error("percentage above full scale");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PCT) |-> dvs_q != '0)
    else $error("divide by zero");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_MEAN)
    else $error("batch popped without starting the mean");

endmodule

// ----- sv/trimmed_mean_moisture_scaler_core.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_moisture_scaler_core
// olympic trimmed mean of converter samples scaled to a moisture percentage
// ----------------------------------------------------------------------------
// The front end takes one sample beat per clock and keeps the running sum,
// minimum, maximum and count. Every SAMPLE_COUNT samples it hands the batch
// through a two-entry queue to the back end and starts a fresh batch in the
// next cycle. The back end forms the trimmed mean (sum less minimum and
// maximum, over SAMPLE_COUNT - 2) by multiplying with a fixed reciprocal,
// then runs a one-bit-per-cycle divider for
// (dry - clamped mean) * 100 / (dry - soaked).
// The back end takes a batch from the queue only while idle, and with bad
// calibration it skips the divider. When the queue is full, the closing
// beat of a batch waits for queue room.
// A result beat holds in the output register until taken while the next
// batch is already being worked on. With soaked not below dry the result has
// bad_calibration set and a percentage of 0. Calibration writes take effect
// on the next result computed; register indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module trimmed_mean_moisture_scaler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tmms_pkg::SAMPLE_W-1:0]  sample_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tmms_pkg::PCT_W-1:0]     moisture_percent_o,
  output logic [tmms_pkg::SAMPLE_W-1:0]  trimmed_average_o,
  output logic                           bad_calibration_o,
  // calibration register write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tmms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tmms_pkg::SAMPLE_W-1:0]  cfg_data_i
);
  import tmms_pkg::*;

  cal_t   cal_q;
  logic   push, full, pop, batch_valid;
  batch_t push_data, pop_data;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.dry    <= SAMPLE_MAX;
      cal_q.soaked <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_DRY) begin
        cal_q.dry <= cfg_data_i;
      end
      if (cfg_index_i == REG_SOAKED) begin
        cal_q.soaked <= cfg_data_i;
      end
    end
  end

  // accumulation of one batch
  tmms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // decouples accumulation from the divider
  tmms_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (batch_valid),
    .pop_data_o  (pop_data)
  );

  // mean, clamp and scaling
  tmms_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (batch_valid),
    .batch_i            (pop_data),
    .pop_o              (pop),
    .cal_i              (cal_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .moisture_percent_o (moisture_percent_o),
    .trimmed_average_o  (trimmed_average_o),
    .bad_calibration_o  (bad_calibration_o)
  );

endmodule
